### hdl/fnne_pkg.sv
`default_nettype none
package fnne_pkg;

  typedef struct packed {
    logic signed [31:0] element_value;
    logic               secondary_vector;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] node_output;
    logic               divide_error;
  } out_item_t;

  localparam logic [2:0] REG_LAYER  = 3'd0;
  localparam logic [2:0] REG_CENTER = 3'd1;
  localparam logic [2:0] REG_LEFT   = 3'd2;
  localparam logic [2:0] REG_RIGHT  = 3'd3;
  localparam logic [2:0] REG_DMIN   = 3'd4;
  localparam logic [2:0] REG_DMAX   = 3'd5;
  localparam logic [2:0] REG_GAIN   = 3'd6;

  localparam logic [2:0] LAYER_PASS    = 3'd1;
  localparam logic [2:0] LAYER_MEMBER  = 3'd2;
  localparam logic [2:0] LAYER_SOFTMIN = 3'd3;
  localparam logic [2:0] LAYER_SPREAD  = 3'd4;
  localparam logic [2:0] LAYER_RATIO   = 3'd5;

  localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S64_MIN = {1'b1, 63'b0};
  localparam logic [31:0] S32_MAX = {1'b0, {31{1'b1}}};
  localparam logic [31:0] S32_MIN = {1'b1, 31'b0};

endpackage
`default_nettype wire

### hdl/fuzzy_network_node_evaluator.sv
`default_nettype none
// Channel   Signals                          Direction  Moves
// config    cfg_write, cfg_index, cfg_data   in         one register write, no wait
// input     in_valid, in_ready, in_data      in         one vector element
// output    out_valid, out_ready, out_data   out        one node result
// A last element in layer 4 forms two 64 by 64 products, four partial products each on
// the shared 32 by 32 multiplier; in layers 2, 3 and 5 it may run the shared divider,
// which gives one quotient bit per cycle.
// Reset is synchronous; no element is taken while a transaction is being worked on, and
// a finished result waits in the output register while the next element is accepted.
module fuzzy_network_node_evaluator import fnne_pkg::*; #(
  parameter int FRAC_BITS       = 16,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int W_W   = FRAC_BITS + 1;
  localparam longint A_STEP = (longint'(8) << 30) / EXP_TABLE_DEPTH;
  localparam logic [31:0] ONE_Q = 32'(1) << FRAC_BITS;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_ELEM    = 5'd1;
  localparam logic [4:0] ST_L3_T    = 5'd2;
  localparam logic [4:0] ST_L3_IDX  = 5'd3;
  localparam logic [4:0] ST_L3_RD   = 5'd4;
  localparam logic [4:0] ST_L3_W    = 5'd5;
  localparam logic [4:0] ST_L3_ACC  = 5'd6;
  localparam logic [4:0] ST_L4_SQ   = 5'd7;
  localparam logic [4:0] ST_CHECK   = 5'd8;
  localparam logic [4:0] ST_L2_SEL  = 5'd9;
  localparam logic [4:0] ST_DIV_PRE = 5'd10;
  localparam logic [4:0] ST_DIV     = 5'd11;
  localparam logic [4:0] ST_DIV_END = 5'd12;
  localparam logic [4:0] ST_L4_MUL  = 5'd13;
  localparam logic [4:0] ST_L4_SAT  = 5'd14;
  localparam logic [4:0] ST_L4_SUB  = 5'd15;
  localparam logic [4:0] ST_OUT     = 5'd16;

  typedef logic [W_W-1:0] lut_t [EXP_TABLE_DEPTH];

  function automatic longint decay_ratio();
    longint term;
    longint r;
    term = longint'(1) << 30;
    r    = term;
    term = ((term * A_STEP) >>> 30) / 1;  r = r - term;
    term = ((term * A_STEP) >>> 30) / 2;  r = r + term;
    term = ((term * A_STEP) >>> 30) / 3;  r = r - term;
    term = ((term * A_STEP) >>> 30) / 4;  r = r + term;
    term = ((term * A_STEP) >>> 30) / 5;  r = r - term;
    term = ((term * A_STEP) >>> 30) / 6;  r = r + term;
    term = ((term * A_STEP) >>> 30) / 7;  r = r - term;
    term = ((term * A_STEP) >>> 30) / 8;  r = r + term;
    term = ((term * A_STEP) >>> 30) / 9;  r = r - term;
    term = ((term * A_STEP) >>> 30) / 10; r = r + term;
    term = ((term * A_STEP) >>> 30) / 11; r = r - term;
    term = ((term * A_STEP) >>> 30) / 12; r = r + term;
    return r;
  endfunction

  function automatic lut_t build_lut();
    lut_t   tbl;
    longint e;
    longint r;
    e = longint'(1) << 30;
    r = decay_ratio();
    for (int n = 0; n < EXP_TABLE_DEPTH; n++) begin
      if (n > 0) e = (e * r) >>> 30;
      tbl[n] = W_W'(e >>> (30 - FRAC_BITS));
    end
    return tbl;
  endfunction

  localparam lut_t DECAY_LUT = build_lut();

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  logic [2:0]         layer_select;
  logic signed [31:0] tri_center, domain_min, domain_max;
  logic [30:0]        tri_left_spread, tri_right_spread;
  logic [20:0]        softmin_gain;

  logic [4:0]         state;
  logic signed [31:0] x_val;
  logic               x_sec, x_last;
  logic [31:0]        x_mag;
  logic signed [31:0] first_value;
  logic               seen_first;
  logic [63:0]        primary_acc, secondary_acc;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [63:0]        t_val, idx_full;
  logic               t_big;
  logic [IDX_W-1:0]   lut_idx;
  logic [W_W-1:0]     lut_q;

  logic signed [31:0] v_clamped;
  logic signed [33:0] v_minus_c;

  logic [63:0]        div_num, div_den, div_rem;
  logic [31:0]        div_q;
  logic               div_frac, div_neg, div_member;
  logic [127:0]       n_shift;
  logic [95:0]        hi96;
  logic [64:0]        div_r2;
  logic               div_ge;
  logic [5:0]         step;
  logic [1:0]         prev_part;

  logic signed [34:0] spread_d, spread_a;
  logic [63:0]        op_a, op_b;
  logic               op_neg, second_pass;
  logic [127:0]       prod_acc, part_shift;
  logic [63:0]        prod_q, prod_sat;
  logic               prod_ovf;
  logic [63:0]        spread_p1, spread_p2;
  logic signed [64:0] spread_diff;

  logic signed [31:0] res_value;
  logic               res_err;

  assign in_ready  = (state == ST_IDLE);
  assign x_mag     = x_val[31] ? (~x_val + 32'd1) : x_val;
  assign t_val     = mul_p >> FRAC_BITS;
  assign t_big     = |(t_val >> (FRAC_BITS + 3));
  assign idx_full  = mul_p >> (FRAC_BITS + 3);
  assign v_minus_c = $signed({{2{v_clamped[31]}}, v_clamped})
                   - $signed({{2{tri_center[31]}}, tri_center});
  assign n_shift   = div_frac ? ({64'b0, div_num} << FRAC_BITS) : {64'b0, div_num};
  assign hi96      = n_shift[127:32];
  assign div_r2    = {div_rem, div_q[31]};
  assign div_ge    = div_r2 >= {1'b0, div_den};
  assign spread_d  = $signed({4'b0, tri_right_spread}) - $signed({4'b0, tri_left_spread});
  assign spread_a  = ($signed({{3{tri_center[31]}}, tri_center}) <<< 1) + spread_d;
  assign prev_part = 2'(step - 6'd1);
  assign prod_ovf  = |(prod_acc >> (64 + FRAC_BITS + 1));
  assign prod_q    = 64'(prod_acc >> (FRAC_BITS + 1));
  assign spread_diff = $signed({spread_p1[63], spread_p1}) - $signed({spread_p2[63], spread_p2});

  always_comb begin
    if (prod_ovf) prod_sat = op_neg ? S64_MIN : S64_MAX;
    else if (op_neg) prod_sat = prod_q[63] ? S64_MIN : (~prod_q + 64'd1);
    else prod_sat = prod_q[63] ? S64_MAX : prod_q;
  end

  always_comb begin
    case (prev_part)
      2'd0:    part_shift = {64'b0, mul_p};
      2'd3:    part_shift = {mul_p, 64'b0};
      default: part_shift = {32'b0, mul_p, 32'b0};
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_ELEM: begin
        mul_a = x_mag;
        mul_b = (layer_select == LAYER_SOFTMIN) ? 32'(softmin_gain) : x_mag;
      end
      ST_L3_T: begin
        mul_a = t_val[31:0];
        mul_b = 32'(EXP_TABLE_DEPTH);
      end
      ST_L3_W: begin
        mul_a = x_mag;
        mul_b = 32'(lut_q);
      end
      ST_L4_MUL: begin
        mul_a = step[1] ? op_a[63:32] : op_a[31:0];
        mul_b = step[0] ? op_b[63:32] : op_b[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    lut_q <= DECAY_LUT[lut_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_select     <= LAYER_PASS;
      tri_center       <= '0;
      tri_left_spread  <= '0;
      tri_right_spread <= '0;
      domain_min       <= '0;
      domain_max       <= '0;
      softmin_gain     <= 21'd65536;
      state            <= ST_IDLE;
      first_value      <= '0;
      seen_first       <= 1'b0;
      primary_acc      <= '0;
      secondary_acc    <= '0;
      out_valid        <= 1'b0;
      lut_idx          <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_LAYER:  layer_select     <= cfg_data[2:0];
          REG_CENTER: tri_center       <= cfg_data;
          REG_LEFT:   tri_left_spread  <= cfg_data[30:0];
          REG_RIGHT:  tri_right_spread <= cfg_data[30:0];
          REG_DMIN:   domain_min       <= cfg_data;
          REG_DMAX:   domain_max       <= cfg_data;
          REG_GAIN:   softmin_gain     <= cfg_data[20:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            x_val  <= in_data.element_value;
            x_sec  <= in_data.secondary_vector;
            x_last <= in_data.last_element;
            state  <= ST_ELEM;
          end
        end
        ST_ELEM: begin
          state <= ST_CHECK;
          if (layer_select == LAYER_RATIO) begin
            if (x_sec) secondary_acc <= sat_add64(secondary_acc, 64'(x_val));
            else primary_acc <= sat_add64(primary_acc, 64'(x_val));
          end else if (!x_sec) begin
            unique case (layer_select)
              LAYER_PASS, LAYER_MEMBER: begin
                if (!seen_first) begin
                  first_value <= x_val;
                  seen_first  <= 1'b1;
                end
              end
              LAYER_SOFTMIN: state <= ST_L3_T;
              LAYER_SPREAD: begin
                primary_acc <= sat_add64(primary_acc, 64'(x_val));
                state       <= ST_L4_SQ;
              end
              default: ;
            endcase
          end
        end
        ST_L3_T: begin
          if (x_val[31] || mul_p == 64'd0) begin
            lut_idx <= '0;
            state   <= ST_L3_RD;
          end else if (t_big) begin
            lut_idx <= IDX_W'(EXP_TABLE_DEPTH - 1);
            state   <= ST_L3_RD;
          end else begin
            state <= ST_L3_IDX;
          end
        end
        ST_L3_IDX: begin
          lut_idx <= idx_full[IDX_W-1:0];
          state   <= ST_L3_RD;
        end
        ST_L3_RD: state <= ST_L3_W;
        ST_L3_W: begin
          secondary_acc <= sat_add64(secondary_acc, 64'(lut_q));
          state         <= ST_L3_ACC;
        end
        ST_L3_ACC: begin
          primary_acc <= sat_add64(primary_acc, x_val[31] ? (~mul_p + 64'd1) : mul_p);
          state       <= ST_CHECK;
        end
        ST_L4_SQ: begin
          secondary_acc <= sat_add64(secondary_acc, mul_p >> FRAC_BITS);
          state         <= ST_CHECK;
        end
        ST_CHECK: begin
          res_value <= '0;
          res_err   <= 1'b0;
          if (!x_last) begin
            state <= ST_IDLE;
          end else begin
            unique case (layer_select)
              LAYER_PASS: begin
                res_value <= first_value;
                state     <= ST_OUT;
              end
              LAYER_MEMBER: begin
                if (first_value > domain_max) v_clamped <= domain_max;
                else if (first_value < domain_min) v_clamped <= domain_min;
                else v_clamped <= first_value;
                state <= ST_L2_SEL;
              end
              LAYER_SOFTMIN, LAYER_RATIO: begin
                if (secondary_acc == 64'd0) begin
                  res_err <= 1'b1;
                  state   <= ST_OUT;
                end else begin
                  div_num    <= mag64(primary_acc);
                  div_den    <= mag64(secondary_acc);
                  div_frac   <= (layer_select == LAYER_RATIO);
                  div_neg    <= primary_acc[63] ^ secondary_acc[63];
                  div_member <= 1'b0;
                  state      <= ST_DIV_PRE;
                end
              end
              LAYER_SPREAD: begin
                op_a        <= 64'(spread_a[34] ? (~spread_a + 35'sd1) : spread_a);
                op_b        <= mag64(primary_acc);
                op_neg      <= spread_a[34] ^ primary_acc[63];
                second_pass <= 1'b0;
                prod_acc    <= '0;
                step        <= '0;
                state       <= ST_L4_MUL;
              end
              default: state <= ST_OUT;
            endcase
          end
        end
        ST_L2_SEL: begin
          div_frac   <= 1'b1;
          div_neg    <= 1'b0;
          div_member <= 1'b1;
          if (!v_minus_c[33] && v_minus_c <= $signed({3'b0, tri_right_spread})) begin
            if (tri_right_spread == 31'd0) begin
              res_value <= ONE_Q;
              state     <= ST_OUT;
            end else begin
              div_num <= 64'(v_minus_c[32:0]);
              div_den <= 64'(tri_right_spread);
              state   <= ST_DIV_PRE;
            end
          end else if (v_minus_c[33] && -v_minus_c <= $signed({3'b0, tri_left_spread})) begin
            div_num <= 64'(34'(-v_minus_c));
            div_den <= 64'(tri_left_spread);
            state   <= ST_DIV_PRE;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_DIV_PRE: begin
          if (hi96 >= {32'b0, div_den}) begin
            res_value <= div_neg ? S32_MIN : S32_MAX;
            state     <= ST_OUT;
          end else begin
            div_rem <= hi96[63:0];
            div_q   <= n_shift[31:0];
            step    <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_rem <= div_ge ? 64'(div_r2 - {1'b0, div_den}) : div_r2[63:0];
          div_q   <= {div_q[30:0], div_ge};
          step    <= step + 6'd1;
          if (step == 6'd31) state <= ST_DIV_END;
        end
        ST_DIV_END: begin
          if (div_member) res_value <= ONE_Q - div_q;
          else if (div_neg) res_value <= (div_q > S32_MIN) ? S32_MIN : (~div_q + 32'd1);
          else res_value <= div_q[31] ? S32_MAX : div_q;
          state <= ST_OUT;
        end
        ST_L4_MUL: begin
          if (step != 6'd0) prod_acc <= prod_acc + part_shift;
          step <= step + 6'd1;
          if (step == 6'd4) state <= ST_L4_SAT;
        end
        ST_L4_SAT: begin
          if (!second_pass) begin
            spread_p1   <= prod_sat;
            op_a        <= 64'(spread_d[34] ? (~spread_d + 35'sd1) : spread_d);
            op_b        <= mag64(secondary_acc);
            op_neg      <= spread_d[34] ^ secondary_acc[63];
            second_pass <= 1'b1;
            prod_acc    <= '0;
            step        <= '0;
            state       <= ST_L4_MUL;
          end else begin
            spread_p2 <= prod_sat;
            state     <= ST_L4_SUB;
          end
        end
        ST_L4_SUB: begin
          if (spread_diff > 65'sd2147483647) res_value <= S32_MAX;
          else if (spread_diff < -65'sd2147483648) res_value <= S32_MIN;
          else res_value <= spread_diff[31:0];
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_data.node_output  <= res_value;
            out_data.divide_error <= res_err;
            out_valid     <= 1'b1;
            first_value   <= '0;
            seen_first    <= 1'b0;
            primary_acc   <= '0;
            secondary_acc <= '0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/fnne_checker.sv
`default_nettype none
module fnne_props import fnne_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A result offered but not taken stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // The node works on one element at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // An element that does not close the evaluation gives no result.
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_data.last_element && !out_valid |=> !out_valid)
    else $error("result without a last element");

  // A failed division reports a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.divide_error |-> out_data.node_output == 32'sd0)
    else $error("division error with non-zero output");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind fuzzy_network_node_evaluator fnne_props u_fnne_props (.*);
`default_nettype wire
